// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/stb_pkg.sv
package stb_pkg;

   // Field widths of the transactions
   localparam int FUNC_W  = 1;
   localparam int WPOS_W  = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 9;
   localparam int FPOS_W  = 8;

   localparam int DEFAULT_TABLE_DEPTH = 256;

   // Operation codes on req_func
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic wr;         // store request value into the table
      logic load;       // latch key and initial bounds
      logic issue;      // read the first midpoint
      logic step;       // narrow the bounds and read the next midpoint
      logic mark_hit;   // record a match
      logic mark_miss;  // record not-found
      logic out_load;   // move the recorded outcome into the output register
   } stb_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic range_empty;  // registered bounds hold no entry
      logic key_eq;       // key equals the entry just read
      logic next_empty;   // bounds after this probe hold no entry
   } stb_status_type;

endpackage

// File: hw/rtl/stb_ram.sv
module stb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/stb_ctrl.sv
module stb_ctrl
   import stb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [FUNC_W-1:0]   req_func,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  stb_status_type      status,
   output stb_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_PROBE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one transaction: store a write on accept, or load bounds, probe and deliver a search
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            if (status.range_empty) begin
               cmd.mark_miss = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.issue = 1'b1;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.key_eq) begin
               cmd.mark_hit = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               if (status.next_empty) begin
                  cmd.mark_miss = 1'b1;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result while stalled, drop it once taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/stb_datapath.sv
module stb_datapath
   import stb_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [COUNT_W-1:0]        csr_element_count,
   input  logic [WPOS_W-1:0]         req_write_position,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  stb_cmd_type               cmd,
   output stb_status_type            status,
   output logic                      rsp_found,
   output logic [FPOS_W-1:0]         rsp_found_position
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CNTW > COUNT_W) ? CNTW : COUNT_W;

   logic [COUNT_W-1:0]        count_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [CNTW-1:0]           lo_ff, lo_in;
   logic [CNTW-1:0]           hi_ff, hi_in;   // exclusive upper bound
   logic [AW-1:0]             mid_ff, mid_in;
   logic                      res_found_ff;
   logic                      rsp_found_ff;
   logic [FPOS_W-1:0]         rsp_pos_ff;
   logic [CNTW-1:0]           count_sat;
   logic [CNTW-1:0]           mid_ext;
   logic [VALUE_W-1:0]        rd_data;
   logic                      key_lt;
   logic                      wr_en;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;

   // Floor midpoint of the inclusive range lo .. hi-1
   function automatic logic [AW-1:0] mid_of(input logic [CNTW-1:0] lo,
                                            input logic [CNTW-1:0] hi);
      logic [CNTW:0] sum;
      sum = {1'b0, lo} + {1'b0, hi} - {{CNTW{1'b0}}, 1'b1};
      return sum[AW:1];
   endfunction

   // Saturate the entry count at the table depth
   always_comb begin
      if (CMPW'(count_ff) > CMPW'(TABLE_DEPTH)) begin
         count_sat = CNTW'(TABLE_DEPTH);
      end else begin
         count_sat = CNTW'(count_ff);
      end
   end

   // Compare the key with the entry read at mid_ff
   assign key_lt  = key_ff < $signed(rd_data);
   assign mid_ext = CNTW'(mid_ff);

   // Narrow the bounds on a step, otherwise load or hold
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      mid_in = mid_ff;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = count_sat;
      end else if (cmd.step) begin
         if (key_lt) begin
            hi_in = mid_ext;
         end else begin
            lo_in = mid_ext + CNTW'(1);
         end
      end
      if (cmd.issue || cmd.step) begin
         mid_in = mid_of(lo_in, hi_in);
      end
   end

   assign status.range_empty = lo_ff >= hi_ff;
   assign status.key_eq      = key_ff == $signed(rd_data);
   assign status.next_empty  = lo_in >= hi_in;

   // Table port: writes come straight from the request, reads from the search
   assign wr_en   = cmd.wr && (32'(req_write_position) < 32'(TABLE_DEPTH));
   assign rd_en   = cmd.issue || cmd.step;
   assign rd_addr = mid_in;

   stb_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_write_position)),
      .wr_data (req_item_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_element_count;
      end
   end

   // Search registers and output payload
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      if (cmd.load) begin
         key_ff <= req_item_value;
      end
      if (cmd.mark_hit) begin
         res_found_ff <= 1'b1;
      end else if (cmd.mark_miss) begin
         res_found_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_found_ff ? FPOS_W'(mid_ff) : '0;
      end
   end

   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_pos_ff;

endmodule

// File: hw/rtl/sorted_table_binary_search.sv
// Channel   Ports                                         Direction
// req       req_valid req_stall req_func                  in  (stall out)
//           req_write_position req_item_value
// rsp       rsp_valid rsp_stall rsp_found                 out (stall in)
//           rsp_found_position
// csr       csr_valid csr_ready csr_element_count         in  (ready out)
//
// A write is stored as it is accepted. A search passes through LOAD, then PROBE
// for each of its P probes (at most 9 for 256 entries), then DONE: each probe
// is one table RAM read plus one compare on the registered data.
// Reset clears the entry count, the controller and rsp_valid; the table is not
// cleared. A stalled result holds in the output register; writes are still
// accepted behind it, and a finished search waits until the register frees.
module sorted_table_binary_search
   import stb_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [WPOS_W-1:0]         req_write_position,
   input  logic signed [VALUE_W-1:0] req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [FPOS_W-1:0]         rsp_found_position,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [COUNT_W-1:0]        csr_element_count
);

`include "assert_macros.svh"

   stb_cmd_type    cmd;
   stb_status_type status;
   logic           search_take;
   logic           write_take;

   assign csr_ready = 1'b1;

   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stb_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_element_count  (csr_element_count),
      .req_write_position (req_write_position),
      .req_item_value     (req_item_value),
      .cmd                (cmd),
      .status             (status),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position)
   );

   // Accepted request transactions by operation
   assign search_take = req_valid && !req_stall && (req_func == FUNC_SEARCH);
   assign write_take  = req_valid && !req_stall && (req_func == FUNC_WRITE);

   // A search keeps the input closed on the following cycle
   `ASSERT_NEXT(a_search_busy, clock, reset, search_take, req_stall)

   // A write never produces a result
   `ASSERT_NEXT(a_write_silent, clock, reset, write_take && !rsp_valid, !rsp_valid)

   // A miss reports position zero
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_found_position == '0)

endmodule
